// ===== rtl/ipv4v_pkg.sv =====
// Package: shared types and character constants for the IPv4 address/port text validator.
`timescale 1ns / 1ps
`default_nettype none
package ipv4v_pkg;

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [16:0] OCTET_MAX  = 17'd255;
  localparam logic [16:0] PORT_MAX   = 17'd65535;
  localparam logic [16:0] VALUE_SAT  = 17'd65536;
  localparam logic [2:0]  IDX_FOURTH = 3'd3;
  localparam logic [2:0]  IDX_PORT   = 3'd4;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] ip_address;
    logic [15:0] port_number;
  } ipv4v_res_t;

endpackage
`default_nettype wire

// ===== rtl/ipv4v_ifs.sv =====
// Interfaces: character input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface ipv4v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface ipv4v_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] ip_address;
  logic [15:0] port_number;

  modport source (output valid, output valid_res, output ip_address, output port_number,
                  input ready);
  modport sink (input valid, input valid_res, input ip_address, input port_number,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/ipv4v_core.sv =====
// Parser core: per-character field state and the end-of-string verdict.
`timescale 1ns / 1ps
`default_nettype none
module ipv4v_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [7:0]           char_code,
  input  wire logic                 is_last,
  output ipv4v_pkg::ipv4v_res_t     res
);
  import ipv4v_pkg::*;

  logic [2:0]  field_index, field_index_next;
  logic [16:0] field_value, field_value_next;
  logic        field_has_digit, field_has_digit_next;
  logic        field_leading_zero, field_leading_zero_next;
  logic        error_seen, error_seen_next;
  logic [23:0] octets_done, octets_done_next;
  logic [7:0]  fourth_octet, fourth_octet_next;

  logic [19:0] acc;
  logic        octet_ok;
  logic        ok;

  always_comb begin
    acc      = {field_value, 3'b000} + {2'b00, field_value, 1'b0}
               + {12'd0, char_code - CHAR_ZERO};
    octet_ok = field_has_digit && (field_value <= OCTET_MAX);

    field_index_next        = field_index;
    field_value_next        = field_value;
    field_has_digit_next    = field_has_digit;
    field_leading_zero_next = field_leading_zero;
    error_seen_next         = error_seen;
    octets_done_next        = octets_done;
    fourth_octet_next       = fourth_octet;

    if (!error_seen) begin
      if (char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
        if (field_has_digit && field_leading_zero) begin
          error_seen_next = 1'b1;
        end else begin
          if (!field_has_digit && char_code == CHAR_ZERO) field_leading_zero_next = 1'b1;
          field_has_digit_next = 1'b1;
          if (acc > {3'b000, PORT_MAX}) begin
            field_value_next = VALUE_SAT;
            error_seen_next  = 1'b1;
          end else begin
            field_value_next = acc[16:0];
          end
        end
      end else if (char_code == CHAR_DOT) begin
        if (field_index < IDX_FOURTH && octet_ok) begin
          octets_done_next        = {octets_done[15:0], field_value[7:0]};
          field_index_next        = field_index + 3'd1;
          field_value_next        = '0;
          field_has_digit_next    = 1'b0;
          field_leading_zero_next = 1'b0;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (char_code == CHAR_COLON) begin
        if (field_index == IDX_FOURTH && octet_ok) begin
          fourth_octet_next       = field_value[7:0];
          field_index_next        = IDX_PORT;
          field_value_next        = '0;
          field_has_digit_next    = 1'b0;
          field_leading_zero_next = 1'b0;
        end else begin
          error_seen_next = 1'b1;
        end
      end else begin
        error_seen_next = 1'b1;
      end
    end

    ok = !error_seen_next && field_index_next == IDX_PORT && field_has_digit_next
         && field_value_next <= PORT_MAX;
    res.valid_res   = ok;
    res.ip_address  = ok ? {octets_done_next, fourth_octet_next} : 32'd0;
    res.port_number = ok ? field_value_next[15:0] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      field_index        <= '0;
      field_value        <= '0;
      field_has_digit    <= 1'b0;
      field_leading_zero <= 1'b0;
      error_seen         <= 1'b0;
      octets_done        <= '0;
      fourth_octet       <= '0;
    end else if (step) begin
      field_index        <= field_index_next;
      field_value        <= field_value_next;
      field_has_digit    <= field_has_digit_next;
      field_leading_zero <= field_leading_zero_next;
      error_seen         <= error_seen_next;
      octets_done        <= octets_done_next;
      fourth_octet       <= fourth_octet_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ipv4_port_text_validator_unit.sv =====
// Top level: input register, parser core and result register of the address/port validator.
// Path: a last character taken into the input register goes through the parser core into the result register on out_ch.
// Throughput: one character per cycle; input stalls only while a finished result waits
// on out_ch and the registered character is the last of its string.
// Reset (rst, synchronous, active high) empties both registers and clears the parse state.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_port_text_validator_unit (
  input wire logic  clk,
  input wire logic  rst,
  ipv4v_in_if.sink  in_ch,
  ipv4v_out_if.source out_ch
);
  import ipv4v_pkg::*;

  logic       in_valid;
  logic [7:0] char_q;
  logic       last_q;
  logic       out_valid;
  ipv4v_res_t res;
  ipv4v_res_t res_q;
  logic       out_free;
  logic       step;

  assign out_free    = !out_valid || out_ch.ready;
  assign step        = in_valid && (!last_q || out_free);
  assign in_ch.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      char_q <= in_ch.char_code;
      last_q <= in_ch.is_last;
    end
  end

  ipv4v_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (char_q),
    .is_last   (last_q),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && last_q) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last_q) res_q <= res;
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.valid_res   = res_q.valid_res;
  assign out_ch.ip_address  = res_q.ip_address;
  assign out_ch.port_number = res_q.port_number;

endmodule
`default_nettype wire

// ===== rtl/ipv4v_checker.sv =====
// Checker: port-level assertions for the validator top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module ipv4v_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        valid_res,
  input wire logic [31:0] ip_address,
  input wire logic [15:0] port_number
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (ip_address == 32'd0 && port_number == 16'd0))
    else $error("invalid result carries nonzero address or port");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(valid_res)
      && $stable(ip_address) && $stable(port_number)))
    else $error("stalled result changed");

endmodule

bind ipv4_port_text_validator_unit ipv4v_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .valid_res   (out_ch.valid_res),
  .ip_address  (out_ch.ip_address),
  .port_number (out_ch.port_number)
);
`default_nettype wire
